### src/sdq_pkg.sv
// Shared types and sizing constants for the sleep delta queue.
// No dependencies; every other file in src refers to this package by scoped names.
package sdq_pkg;

   // Sizing of the list store and of the time values
   localparam int CAPACITY    = 16;
   localparam int TIME_BITS   = 16;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

   // Command queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_WRITE,
      ST_FINISH
   } eng_state_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  thread_id;
      logic [15:0] sleep_time;
   } req_type;

   typedef struct packed {
      logic [7:0]  popped_thread;
      logic        pop_valid;
      status_type  status;
      logic [4:0]  entry_count;
      logic [15:0] head_delta;
   } rsp_type;

   // Classified command as held in the queue
   typedef struct packed {
      logic                 is_pop;
      logic [7:0]           thread_id;
      logic [TIME_BITS-1:0] wake_time;
   } cmd_type;

endpackage

### src/sdq_front.sv
// Front end of the sleep delta queue: accepts request items, decodes them
// into commands and holds them in a short queue. Depends on sdq_pkg.
module sdq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdq_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output sdq_pkg::cmd_type cmd
);

   sdq_pkg::cmd_type                  q_ff [sdq_pkg::QUEUE_DEPTH];
   logic [sdq_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sdq_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sdq_pkg::QCOUNT_BITS-1:0]   count_ff, count_in;
   sdq_pkg::cmd_type                  cmd_in;
   logic                              push;
   logic                              pop;

   // Decode the request into a command
   always_comb begin
      cmd_in.is_pop    = (req_data.opcode == sdq_pkg::OP_POP);
      cmd_in.thread_id = req_data.thread_id;
      cmd_in.wake_time = sdq_pkg::TIME_BITS'(req_data.sleep_time);
   end

   assign req_stall = (count_ff == sdq_pkg::QCOUNT_BITS'(sdq_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = q_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sdq_pkg::QPTR_BITS'(sdq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sdq_pkg::QPTR_BITS'(sdq_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the decoded item
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### src/sdq_engine.sv
// Back end of the sleep delta queue: holds the delta list, walks it for
// inserts, shifts it for inserts and pops, and registers the result. Depends on sdq_pkg.
module sdq_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  sdq_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdq_pkg::rsp_type rsp_data
);

   localparam int TB = sdq_pkg::TIME_BITS;

   sdq_pkg::eng_state_type            state_ff, state_in;
   sdq_pkg::cmd_type                  cmd_ff;
   logic [sdq_pkg::COUNT_BITS-1:0]    occ_ff;
   logic [sdq_pkg::IDX_BITS-1:0]      pos_ff;
   logic [TB-1:0]                     cum_ff;
   logic [TB-1:0]                     nd_ff;
   logic [TB-1:0]                     follow_ff;
   logic [TB-1:0]                     delta_ff [sdq_pkg::CAPACITY];
   logic [7:0]                        id_ff    [sdq_pkg::CAPACITY];
   logic                              rsp_valid_ff;
   sdq_pkg::rsp_type                  rsp_ff, rsp_in;

   logic          out_free;
   logic          full;
   logic [TB-1:0] rd_delta;
   logic [TB:0]   sum;
   logic          advance;
   logic          walk_stop;
   logic          do_insert;
   logic          do_finish;
   logic          do_pop;

   // Walk datapath: one stored delta a cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (occ_ff == sdq_pkg::COUNT_BITS'(sdq_pkg::CAPACITY));
   assign rd_delta = delta_ff[pos_ff];
   assign sum      = {1'b0, cum_ff} + {1'b0, rd_delta};
   assign advance  = (sdq_pkg::COUNT_BITS'(pos_ff) < occ_ff) &&
                     (sum <= {1'b0, cmd_ff.wake_time});

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdq_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               state_in = (cmd.is_pop || full) ? sdq_pkg::ST_FINISH : sdq_pkg::ST_WALK;
            end
         end
         sdq_pkg::ST_WALK: begin
            if (!advance) begin
               state_in = sdq_pkg::ST_WRITE;
            end
         end
         sdq_pkg::ST_WRITE:  state_in = sdq_pkg::ST_IDLE;
         sdq_pkg::ST_FINISH: state_in = sdq_pkg::ST_IDLE;
         default:            state_in = sdq_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_take  = 1'b0;
      walk_stop = 1'b0;
      do_insert = 1'b0;
      do_finish = 1'b0;
      case (state_ff)
         sdq_pkg::ST_IDLE:   cmd_take  = cmd_valid && out_free;
         sdq_pkg::ST_WALK:   walk_stop = !advance;
         sdq_pkg::ST_WRITE:  do_insert = 1'b1;
         sdq_pkg::ST_FINISH: do_finish = 1'b1;
         default:            cmd_take  = 1'b0;
      endcase
   end

   assign do_pop = do_finish && cmd_ff.is_pop && (occ_ff != '0);

   // Compose the result item
   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = sdq_pkg::STATUS_OK;
      if (do_insert) begin
         rsp_in.entry_count = 5'(occ_ff + 1'b1);
         rsp_in.head_delta  = (pos_ff == '0) ? 16'(nd_ff) : 16'(delta_ff[0]);
      end else if (cmd_ff.is_pop) begin
         if (occ_ff == '0) begin
            rsp_in.status = sdq_pkg::STATUS_EMPTY;
         end else begin
            rsp_in.popped_thread = id_ff[0];
            rsp_in.pop_valid     = 1'b1;
            rsp_in.entry_count   = 5'(occ_ff - 1'b1);
            rsp_in.head_delta    = (occ_ff > sdq_pkg::COUNT_BITS'(1)) ?
                                   16'(delta_ff[1]) : 16'd0;
         end
      end else begin
         rsp_in.status      = sdq_pkg::STATUS_FULL;
         rsp_in.entry_count = 5'(occ_ff);
         rsp_in.head_delta  = 16'(delta_ff[0]);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdq_pkg::ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_insert) begin
            occ_ff <= occ_ff + 1'b1;
         end else if (do_pop) begin
            occ_ff <= occ_ff - 1'b1;
         end
         if (do_insert || do_finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk registers and held result
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         cmd_ff <= cmd;
         pos_ff <= '0;
         cum_ff <= '0;
      end else if ((state_ff == sdq_pkg::ST_WALK) && advance) begin
         cum_ff <= sum[TB-1:0];
         pos_ff <= pos_ff + 1'b1;
      end
      if (walk_stop) begin
         nd_ff     <= cmd_ff.wake_time - cum_ff;
         follow_ff <= sum[TB-1:0] - cmd_ff.wake_time;
      end
      if (do_insert || do_finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // List cells: open a gap on insert, close the head on pop
   for (genvar i = 0; i < sdq_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (do_insert && (pos_ff == '0)) begin
               delta_ff[i] <= nd_ff;
               id_ff[i]    <= cmd_ff.thread_id;
            end else if (do_pop) begin
               delta_ff[i] <= delta_ff[i+1];
               id_ff[i]    <= id_ff[i+1];
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (do_insert && (sdq_pkg::IDX_BITS'(i) == pos_ff)) begin
               delta_ff[i] <= nd_ff;
               id_ff[i]    <= cmd_ff.thread_id;
            end else if (do_insert && (sdq_pkg::IDX_BITS'(i) > pos_ff)) begin
               delta_ff[i] <= (sdq_pkg::IDX_BITS'(i - 1) == pos_ff) ?
                              follow_ff : delta_ff[i-1];
               id_ff[i]    <= id_ff[i-1];
            end else if (do_pop && (i < sdq_pkg::CAPACITY - 1)) begin
               delta_ff[i] <= delta_ff[(i + 1) % sdq_pkg::CAPACITY];
               id_ff[i]    <= id_ff[(i + 1) % sdq_pkg::CAPACITY];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= sdq_pkg::COUNT_BITS'(sdq_pkg::CAPACITY))
      else $error("occupancy beyond capacity");

   a_walk_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdq_pkg::ST_WALK) |-> (sdq_pkg::COUNT_BITS'(pos_ff) <= occ_ff))
      else $error("walk ran past the last entry");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdq_pkg::ST_WRITE) |=> (occ_ff == $past(occ_ff) + 1'b1))
      else $error("insert did not add one entry");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (occ_ff == $past(occ_ff) - 1'b1))
      else $error("pop did not remove one entry");
`endif

endmodule

### src/sleep_delta_queue.sv
// Top level of the sleep delta queue: joins the request front end and the list engine.
// Depends on sdq_pkg, sdq_front and sdq_engine.
//
// A delta-list timer queue of up to sdq_pkg::CAPACITY sleeping threads, each
// entry holding its delay relative to the entry ahead of it. A request item
// either inserts a thread (placed behind every entry with an equal or earlier
// wake time) or pops the head; each request gives exactly one response item
// with status, entry count and head delta. Requests enter a two-deep command
// queue, so requests are still accepted while a response waits, until the
// queue is full. In the engine a pop, a pop on an empty queue or an insert into
// a full queue goes from the idle state straight to the finish state; an
// accepted insert walks the list, reading one stored delta per cycle, past
// every entry it passes, and then writes the new entry. No clearing pass is
// needed after reset.
module sleep_delta_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdq_pkg::rsp_type rsp_data
);

   logic             cmd_valid;
   logic             cmd_take;
   sdq_pkg::cmd_type cmd;

   // Accept and decode requests
   sdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   // Carry out commands on the list
   sdq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
